/* design/msps_pkg.sv */
// Package for the marker stream phase splitter.
// Holds the marker byte tables, phase, result and error codes, and sizing helpers.
// No dependencies; the front, queue, back and top files import it.
`timescale 1ns / 1ps

package msps_pkg;

  localparam int unsigned MK_NUM = 6;
  localparam int unsigned MK_MAX = 29;

  // A complete separator token sits at this offset inside a tool marker prefix,
  // and is complete once that prefix reaches the minimum length below.
  localparam int unsigned DSML_AT       = 3;
  localparam int unsigned DSML_TOOL_MIN = 13;

  localparam logic [23:0] LIMIT_RESET = 24'h800000;

  typedef enum logic [2:0] {
    MK_TOOL     = 3'd0,
    MK_BOS      = 3'd1,
    MK_EOS      = 3'd2,
    MK_THINK    = 3'd3,
    MK_ENDTHINK = 3'd4,
    MK_DSML     = 3'd5
  } mk_e;

  typedef enum logic [1:0] {
    PH_REASON  = 2'd0,
    PH_CONTENT = 2'd1,
    PH_TOOLS   = 2'd2,
    PH_END     = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    K_TEXT  = 2'd0,
    K_EVENT = 2'd1,
    K_ERROR = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_BAD_MARKER = 3'd1,
    ERR_AFTER_END  = 3'd2,
    ERR_OVER_LIMIT = 3'd3,
    ERR_FINISHED   = 3'd4
  } err_e;

  typedef enum logic {
    CMD_FEED   = 1'b0,
    CMD_FINISH = 1'b1
  } cmd_e;

  typedef enum logic {
    CFG_START = 1'b0,
    CFG_LIMIT = 1'b1
  } cfg_e;

  localparam int unsigned MK_LEN [MK_NUM] = '{23, 29, 27, 7, 8, 10};

  localparam logic [7:0] MK_TAB [MK_NUM][MK_MAX] = '{
    '{8'h0A, 8'h0A, 8'h3C, 8'hEF, 8'hBD, 8'h9C, 8'h44, 8'h53, 8'h4D, 8'h4C,
      8'hEF, 8'hBD, 8'h9C, 8'h74, 8'h6F, 8'h6F, 8'h6C, 8'h5F, 8'h63, 8'h61,
      8'h6C, 8'h6C, 8'h73, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h3C, 8'hEF, 8'hBD, 8'h9C, 8'h62, 8'h65, 8'h67, 8'h69, 8'h6E, 8'hE2,
      8'h96, 8'h81, 8'h6F, 8'h66, 8'hE2, 8'h96, 8'h81, 8'h73, 8'h65, 8'h6E,
      8'h74, 8'h65, 8'h6E, 8'h63, 8'h65, 8'hEF, 8'hBD, 8'h9C, 8'h3E},
    '{8'h3C, 8'hEF, 8'hBD, 8'h9C, 8'h65, 8'h6E, 8'h64, 8'hE2, 8'h96, 8'h81,
      8'h6F, 8'h66, 8'hE2, 8'h96, 8'h81, 8'h73, 8'h65, 8'h6E, 8'h74, 8'h65,
      8'h6E, 8'h63, 8'h65, 8'hEF, 8'hBD, 8'h9C, 8'h3E, 8'h00, 8'h00},
    '{8'h3C, 8'h74, 8'h68, 8'h69, 8'h6E, 8'h6B, 8'h3E, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h3C, 8'h2F, 8'h74, 8'h68, 8'h69, 8'h6E, 8'h6B, 8'h3E, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hEF, 8'hBD, 8'h9C, 8'h44, 8'h53, 8'h4D, 8'h4C, 8'hEF, 8'hBD, 8'h9C,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  // Width of one work descriptor: window bytes, start index, byte count and the
  // channel, event, phase, error and code fields.
  function automatic int unsigned desc_bits(int unsigned hold);
    return (hold + 1) * 8 + $clog2(hold + 1) + $clog2(hold + 2) + 8;
  endfunction

endpackage

/* design/msps_if.sv */
// Stream and configuration channel interfaces of the marker stream phase splitter.
// No dependencies.
`timescale 1ns / 1ps

interface msps_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;
  modport source (output valid, cmd, data_byte, input ready);
  modport sink (input valid, cmd, data_byte, output ready);
endinterface

interface msps_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic       channel;
  logic [1:0] new_phase;
  logic [2:0] error_code;
  logic       last;
  modport source (output valid, kind, out_byte, channel, new_phase, error_code, last,
                  input ready);
  modport sink (input valid, kind, out_byte, channel, new_phase, error_code, last,
                output ready);
endinterface

interface msps_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* design/msps_front.sv */
// Front end: accepts requests, matches markers against the held window and the new
// byte, updates phase and counters, and emits a work descriptor per request that
// has results. Depends on msps_pkg and msps_if.
`timescale 1ns / 1ps

module msps_front #(
  parameter int unsigned HOLD_DEPTH = 28
) (
  input  logic clk_i,
  input  logic rst_ni,
  msps_in_if.sink  in_i,
  msps_cfg_if.sink cfg_i,
  input  logic q_full_i,
  output logic push_o,
  output logic [msps_pkg::desc_bits(HOLD_DEPTH)-1:0] desc_o
);
  import msps_pkg::*;

  localparam int unsigned WD  = HOLD_DEPTH + 1;
  localparam int unsigned HCW = $clog2(HOLD_DEPTH + 1);
  localparam int unsigned CW  = $clog2(WD + 1);
  localparam int unsigned IW  = $clog2(WD);

  typedef struct packed {
    logic [WD-1:0][7:0] win;
    logic [IW-1:0]      start;
    logic [CW-1:0]      cnt;
    logic               chan;
    logic               ev;
    phase_e             ph;
    logic               er;
    err_e               code;
  } desc_t;

  logic [7:0]     win_q [WD];
  logic [7:0]     win_d [WD];
  logic [7:0]     wsh   [WD];
  logic [HCW-1:0] held_q, held_d;
  logic           hdsml_q, hdsml_d;
  phase_e         phase_q, phase_d;
  logic [23:0]    total_q, total_d;
  logic           fin_q, fin_d;
  logic           err_q, err_d;
  err_e           errc_q, errc_d;
  logic [23:0]    limit_q, limit_d;

  logic           accept;
  logic [CW-1:0]  n;
  logic           match [MK_NUM][MK_MAX+1];
  logic [CW-1:0]  keep;
  logic           keep_tool;
  logic           found;
  logic [CW-1:0]  at;
  mk_e            which;
  desc_t          d;

  assign in_i.ready  = !q_full_i;
  assign cfg_i.ready = 1'b1;
  assign accept      = in_i.valid && in_i.ready;
  assign n           = CW'(held_q) + CW'(1);

  // The held window shifted by the new byte; the newest byte sits at the top.
  always_comb begin
    for (int i = 0; i < WD - 1; i++) wsh[i] = win_q[i + 1];
    wsh[WD-1] = in_i.data_byte;
  end

  // match[m][c]: the last c bytes of held text plus new byte equal the first c
  // bytes of marker m.
  always_comb begin : match_logic
    logic ok;
    for (int m = 0; m < MK_NUM; m++) begin
      match[m][0] = 1'b0;
      for (int c = 1; c <= MK_MAX; c++) begin
        ok = (c <= MK_LEN[m]) && (CW'(c) <= n);
        for (int j = 0; j < MK_MAX; j++) begin
          if (j < c) ok = ok && (wsh[WD - c + j] == MK_TAB[m][j]);
        end
        match[m][c] = ok;
      end
    end
  end

  // Held text is always a proper marker prefix, so a complete marker either ends
  // at the new byte or is the separator token inside a held tool marker prefix.
  always_comb begin : search
    logic [CW-1:0] pos;
    keep      = '0;
    keep_tool = 1'b0;
    found     = 1'b0;
    at        = '0;
    which     = MK_TOOL;
    pos       = '0;
    for (int m = 0; m < MK_NUM; m++) begin
      for (int c = 1; c < MK_MAX; c++) begin
        if (match[m][c] && (c < MK_LEN[m]) && (CW'(c) > keep)) begin
          keep      = CW'(c);
          keep_tool = (m == int'(MK_TOOL)) && (c >= DSML_TOOL_MIN);
        end
      end
    end
    for (int m = 0; m < MK_NUM; m++) begin
      if (match[m][MK_LEN[m]]) begin
        pos = n - CW'(MK_LEN[m]);
        if (!found || pos < at) begin
          found = 1'b1;
          at    = pos;
          which = mk_e'(m);
        end
      end
    end
    if (hdsml_q && (!found || CW'(DSML_AT) < at)) begin
      found = 1'b1;
      at    = CW'(DSML_AT);
      which = MK_DSML;
    end
  end

  always_comb begin
    win_d   = win_q;
    held_d  = held_q;
    hdsml_d = hdsml_q;
    phase_d = phase_q;
    total_d = total_q;
    fin_d   = fin_q;
    err_d   = err_q;
    errc_d  = errc_q;
    limit_d = limit_q;

    for (int i = 0; i < WD; i++) d.win[i] = win_q[i];
    d.start = IW'(CW'(WD) - n);
    d.cnt   = '0;
    d.chan  = (phase_q != PH_REASON);
    d.ev    = 1'b0;
    d.ph    = phase_q;
    d.er    = 1'b0;
    d.code  = ERR_NONE;

    if (accept) begin
      if (fin_q) begin
        d.er   = 1'b1;
        d.code = ERR_FINISHED;
      end else if (err_q) begin
        d.er   = 1'b1;
        d.code = errc_q;
      end else if (in_i.cmd == CMD_FEED) begin
        if (phase_q == PH_END) begin
          d.er   = 1'b1;
          d.code = ERR_AFTER_END;
        end else if (total_q >= limit_q) begin
          d.er   = 1'b1;
          d.code = ERR_OVER_LIMIT;
        end else begin
          total_d = total_q + 24'd1;
          if (phase_q != PH_TOOLS) begin
            win_d = wsh;
            for (int i = 0; i < WD; i++) d.win[i] = wsh[i];
            held_d  = '0;
            hdsml_d = 1'b0;
            if (keep != '0 && (!found || (n - keep) <= at)) begin
              d.cnt   = n - keep;
              held_d  = HCW'(keep);
              hdsml_d = keep_tool;
            end else if (!found) begin
              d.cnt = n;
            end else begin
              d.cnt = at;
              if (phase_q == PH_REASON && which == MK_ENDTHINK) begin
                phase_d = PH_CONTENT;
                d.ev    = 1'b1;
                d.ph    = PH_CONTENT;
              end else if (phase_q == PH_CONTENT && which == MK_TOOL) begin
                phase_d = PH_TOOLS;
                d.ev    = 1'b1;
                d.ph    = PH_TOOLS;
              end else if (phase_q == PH_CONTENT && which == MK_EOS) begin
                phase_d = PH_END;
                d.ev    = 1'b1;
                d.ph    = PH_END;
              end else begin
                d.er    = 1'b1;
                d.code  = ERR_BAD_MARKER;
                win_d   = win_q;
                held_d  = held_q;
                hdsml_d = hdsml_q;
              end
            end
          end
        end
        if (d.er) begin
          err_d  = 1'b1;
          errc_d = d.code;
        end
      end else begin
        // Finish: flush the held text unless it carries the separator token.
        if ((phase_q inside {PH_REASON, PH_CONTENT}) && !hdsml_q) begin
          d.cnt   = CW'(held_q);
          d.start = IW'(CW'(WD) - CW'(held_q));
        end
        held_d  = '0;
        hdsml_d = 1'b0;
        fin_d   = 1'b1;
      end
    end

    // The start register only matters for reloading the phase before any byte.
    if (cfg_i.valid) begin
      if (cfg_i.index == CFG_START) begin
        if (total_q == '0 && held_q == '0 && !fin_q && !err_q) begin
          phase_d = cfg_i.data[0] ? PH_REASON : PH_CONTENT;
        end
      end else begin
        limit_d = cfg_i.data;
      end
    end
  end

  assign push_o = accept && (d.cnt != '0 || d.ev || d.er);
  assign desc_o = d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      hdsml_q <= 1'b0;
      phase_q <= PH_REASON;
      total_q <= '0;
      fin_q   <= 1'b0;
      err_q   <= 1'b0;
      errc_q  <= ERR_NONE;
      limit_q <= LIMIT_RESET;
    end else begin
      held_q  <= held_d;
      hdsml_q <= hdsml_d;
      phase_q <= phase_d;
      total_q <= total_d;
      fin_q   <= fin_d;
      err_q   <= err_d;
      errc_q  <= errc_d;
      limit_q <= limit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  a_dsml_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdsml_q |-> held_q >= HCW'(DSML_TOOL_MIN))
    else $error("separator flag set with a short held prefix");

  a_fin_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> held_q == '0 && !hdsml_q)
    else $error("held text remains after finish");

endmodule

/* design/msps_queue.sv */
// Short descriptor queue between the front and back ends, first word fall through.
// Depends on msps_pkg only for the shared import convention.
`timescale 1ns / 1ps

module msps_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             valid_o,
  output logic             full_o
);
  import msps_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [NW-1:0]    cnt_q, cnt_d;

  assign data_o  = mem[rd_q];
  assign valid_o = cnt_q != '0;
  assign full_o  = cnt_q == NW'(DEPTH);

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + NW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem[wr_q] <= data_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("descriptor queue overflow");

endmodule

/* design/msps_back.sv */
// Back end: expands each work descriptor into result items, one per cycle unless the
// receiver stalls, into a registered output stage. Depends on msps_pkg and msps_if.
`timescale 1ns / 1ps

module msps_back #(
  parameter int unsigned HOLD_DEPTH = 28
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic [msps_pkg::desc_bits(HOLD_DEPTH)-1:0] head_i,
  input  logic q_valid_i,
  output logic pop_o,
  msps_out_if.source out_o
);
  import msps_pkg::*;

  localparam int unsigned WD = HOLD_DEPTH + 1;
  localparam int unsigned CW = $clog2(WD + 1);
  localparam int unsigned IW = $clog2(WD);

  typedef struct packed {
    logic [WD-1:0][7:0] win;
    logic [IW-1:0]      start;
    logic [CW-1:0]      cnt;
    logic               chan;
    logic               ev;
    phase_e             ph;
    logic               er;
    err_e               code;
  } desc_t;

  desc_t         head, cur_q, cur_d;
  logic          active_q, active_d;
  logic [IW-1:0] pos_q, pos_d;
  logic [CW-1:0] rem_q, rem_d;
  logic          ev_q, ev_d, er_q, er_d;

  logic          out_valid_q, out_valid_d;
  kind_e         kind_q, kind_d;
  logic [7:0]    byte_q, byte_d;
  logic          chan_q, chan_d;
  phase_e        ph_q, ph_d;
  err_e          code_q, code_d;
  logic          last_q, last_d;

  logic          out_free, fire, load;

  assign head     = head_i;
  assign out_free = !out_valid_q || out_o.ready;
  assign fire     = active_q && out_free;

  always_comb begin
    cur_d       = cur_q;
    active_d    = active_q;
    pos_d       = pos_q;
    rem_d       = rem_q;
    ev_d        = ev_q;
    er_d        = er_q;
    out_valid_d = out_valid_q && !out_o.ready;
    kind_d      = kind_q;
    byte_d      = byte_q;
    chan_d      = chan_q;
    ph_d        = ph_q;
    code_d      = code_q;
    last_d      = last_q;

    if (fire) begin
      out_valid_d = 1'b1;
      byte_d      = '0;
      chan_d      = 1'b0;
      ph_d        = PH_REASON;
      code_d      = ERR_NONE;
      if (rem_q != '0) begin
        kind_d = K_TEXT;
        byte_d = cur_q.win[pos_q];
        chan_d = cur_q.chan;
        last_d = (rem_q == CW'(1)) && !ev_q && !er_q;
        pos_d  = pos_q + IW'(1);
        rem_d  = rem_q - CW'(1);
      end else if (ev_q) begin
        kind_d = K_EVENT;
        ph_d   = cur_q.ph;
        last_d = !er_q;
        ev_d   = 1'b0;
      end else begin
        kind_d = K_ERROR;
        code_d = cur_q.code;
        last_d = 1'b1;
        er_d   = 1'b0;
      end
      if (last_d) active_d = 1'b0;
    end

    load = q_valid_i && (!active_q || (fire && last_d));
    if (load) begin
      cur_d    = head;
      active_d = 1'b1;
      pos_d    = head.start;
      rem_d    = head.cnt;
      ev_d     = head.ev;
      er_d     = head.er;
    end
  end

  assign pop_o = load;

  assign out_o.valid      = out_valid_q;
  assign out_o.kind       = kind_q;
  assign out_o.out_byte   = byte_q;
  assign out_o.channel    = chan_q;
  assign out_o.new_phase  = ph_q;
  assign out_o.error_code = code_q;
  assign out_o.last       = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      rem_q       <= '0;
      ev_q        <= 1'b0;
      er_q        <= 1'b0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
      rem_q       <= rem_d;
      ev_q        <= ev_d;
      er_q        <= er_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    pos_q  <= pos_d;
    kind_q <= kind_d;
    byte_q <= byte_d;
    chan_q <= chan_d;
    ph_q   <= ph_d;
    code_q <= code_d;
    last_q <= last_d;
  end

  a_work_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q && rem_q == '0 |-> ev_q || er_q)
    else $error("active descriptor with nothing left to emit");

  a_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> int'(pos_q) + int'(rem_q) <= int'(WD))
    else $error("text read runs past the window");

endmodule

/* design/marker_stream_phase_splitter_top.sv */
// Top level of the marker stream phase splitter.
// Depends on msps_pkg, msps_if, msps_front, msps_queue and msps_back.
//
// Channels: in_i carries one request per accepted valid/ready edge, either a stream
// byte (cmd feed) or a finish command. out_o delivers result items: released text
// bytes tagged reasoning or content, phase change events and error reports, with
// last set on the final result of each request. cfg_i writes register 0 (start in
// reasoning) or register 1 (byte limit); it is always ready. It is to be written only
// while the block is idle; the block does not enforce this for register 1.
// Throughput: the front end takes one request per cycle while its two-entry
// descriptor queue has room; the back end delivers one result per cycle while the
// receiver takes them. A request that only holds bytes, or that is dropped in the
// tools phase, gives no result.
// Path: a request's descriptor is written into the queue, then loaded into the back
// end's current descriptor register; its first result is then registered for output.
// Reset clears phase to reasoning, counters, flags and the held text, and restores
// the register defaults. When the receiver stalls, the output register holds its
// result, the back end waits, and in_i.ready drops once the queue fills.
`timescale 1ns / 1ps

module marker_stream_phase_splitter_top #(
  parameter int unsigned HOLD_DEPTH = 28
) (
  input  logic clk_i,
  input  logic rst_ni,
  msps_in_if.sink    in_i,
  msps_cfg_if.sink   cfg_i,
  msps_out_if.source out_o
);
  import msps_pkg::*;

  localparam int unsigned DW = desc_bits(HOLD_DEPTH);

  logic          push, pop, q_full, q_valid;
  logic [DW-1:0] desc_in, desc_head;

  msps_front #(.HOLD_DEPTH(HOLD_DEPTH)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cfg_i    (cfg_i),
    .q_full_i (q_full),
    .push_o   (push),
    .desc_o   (desc_in)
  );

  msps_queue #(.WIDTH(DW), .DEPTH(2)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (desc_in),
    .pop_i   (pop),
    .data_o  (desc_head),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  msps_back #(.HOLD_DEPTH(HOLD_DEPTH)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (desc_head),
    .q_valid_i (q_valid),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule
